FILE: rtl/core/pit_pkg.sv
package pit_pkg;

    localparam int LON_W       = 32;
    localparam int LAT_W       = 31;
    localparam int CNT_W       = 7;
    localparam int IDX_W       = 6;
    localparam int MIN_VERTICES = 3;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic wr_en;      // write vertex slot from input payload
        logic ld_point;   // latch query point, clear inside flag
        logic rd_en;      // read one vertex from table
        logic first;      // read primes the previous-vertex register only
        logic ld_result;  // capture result into output register
        logic too_few;    // result is the too-few-vertices case
    } pit_cmd_t;

endpackage

FILE: rtl/core/point_in_polygon_test.sv
// Channel   | Handshake              | Payload
// s_ (in)   | s_valid / s_ready      | s_kind, s_vertex_index, s_point_lon, s_point_lat
// m_ (out)  | m_valid / m_ready      | m_inside_res, m_too_few_vertices
// cfg       | cfg_valid / cfg_ready  | cfg_vertex_count
//
// Vertex item: written straight into the vertex RAM when taken, if its index is in range.
// Query item: the walk reads one vertex a cycle, closing edge first, then three pipeline
// stages drain; the result is then registered, and the next item is taken once it loads.
// With fewer than three vertices the walk is skipped and the result is registered directly.
// Reset (aresetn, synchronous) clears control and the vertex count; the RAM is not cleared.
// A held result does not block the next item; a query finishing while m_ is stalled waits.
module point_in_polygon_test
    import pit_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_kind,
    input  logic [IDX_W-1:0]        s_vertex_index,
    input  logic signed [LON_W-1:0] s_point_lon,
    input  logic signed [LAT_W-1:0] s_point_lat,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_inside_res,
    output logic                    m_too_few_vertices,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CNT_W-1:0]        cfg_vertex_count
);

    localparam int AW = $clog2(MAX_VERTICES);

    pit_cmd_t      cmd;
    logic [AW-1:0] rd_addr;
    logic          pipe_busy;

    pit_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_vertex_index   (s_vertex_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_vertex_count (cfg_vertex_count),
        .pipe_busy        (pipe_busy),
        .cmd              (cmd),
        .rd_addr          (rd_addr)
    );

    pit_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .rd_addr            (rd_addr),
        .s_vertex_index     (s_vertex_index),
        .s_point_lon        (s_point_lon),
        .s_point_lat        (s_point_lat),
        .pipe_busy          (pipe_busy),
        .m_inside_res       (m_inside_res),
        .m_too_few_vertices (m_too_few_vertices)
    );

endmodule

FILE: rtl/core/pit_ram.sv
module pit_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/pit_ctrl.sv
module pit_ctrl
    import pit_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int AW = $clog2(MAX_VERTICES)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [IDX_W-1:0]  s_vertex_index,
    output logic              m_valid,
    input  logic              m_ready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_vertex_count,
    input  logic              pipe_busy,
    output pit_cmd_t          cmd,
    output logic [AW-1:0]     rd_addr
);

    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t         state_reg;
    logic           rd_en_reg;
    logic           first_reg;
    logic           too_few_reg;
    logic [AW-1:0]  rd_addr_reg;
    logic [AW-1:0]  idx_reg;
    logic [CW-1:0]  vcount_reg;
    logic           m_valid_reg;

    logic [CW-1:0]  vcount_next;
    logic           accept;
    logic           slot_ok;
    logic           too_few_now;
    logic           last_edge;
    logic           ld_result;

    // saturate count to table depth
    always_comb begin
        if (32'(cfg_vertex_count) > 32'(MAX_VERTICES)) begin
            vcount_next = CW'(MAX_VERTICES);
        end else begin
            vcount_next = CW'(cfg_vertex_count);
        end
    end

    assign accept      = s_valid && s_ready;
    assign slot_ok     = 32'(s_vertex_index) < 32'(MAX_VERTICES);
    assign too_few_now = vcount_reg < CW'(MIN_VERTICES);
    assign last_edge   = CW'(idx_reg) == (vcount_reg - CW'(1));
    assign ld_result   = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_en_reg   <= 1'b0;
            first_reg   <= 1'b0;
            too_few_reg <= 1'b0;
            rd_addr_reg <= '0;
            idx_reg     <= '0;
            vcount_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                vcount_reg <= vcount_next;
            end
            if (ld_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_kind == KIND_QUERY) begin
                        if (too_few_now) begin
                            too_few_reg <= 1'b1;
                            rd_en_reg   <= 1'b0;
                            first_reg   <= 1'b0;
                            state_reg   <= ST_FINISH;
                        end else begin
                            // closing edge: start from the last vertex
                            too_few_reg <= 1'b0;
                            rd_en_reg   <= 1'b1;
                            first_reg   <= 1'b1;
                            rd_addr_reg <= AW'(vcount_reg - CW'(1));
                            idx_reg     <= '0;
                            state_reg   <= ST_WALK;
                        end
                    end else begin
                        rd_en_reg <= 1'b0;
                        first_reg <= 1'b0;
                    end
                end
                ST_WALK: begin
                    rd_en_reg   <= 1'b1;
                    first_reg   <= 1'b0;
                    rd_addr_reg <= idx_reg;
                    idx_reg     <= idx_reg + AW'(1);
                    if (last_edge) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    rd_en_reg <= 1'b0;
                    first_reg <= 1'b0;
                    if (!pipe_busy && !rd_en_reg) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    rd_en_reg <= 1'b0;
                    first_reg <= 1'b0;
                    if (ld_result) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    rd_en_reg <= 1'b0;
                    first_reg <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign rd_addr   = rd_addr_reg;

    assign cmd.wr_en     = accept && s_kind == KIND_VERTEX && slot_ok;
    assign cmd.ld_point  = accept && s_kind == KIND_QUERY;
    assign cmd.rd_en     = rd_en_reg;
    assign cmd.first     = first_reg;
    assign cmd.ld_result = ld_result;
    assign cmd.too_few   = too_few_reg;

endmodule

FILE: rtl/core/pit_datapath.sv
module pit_datapath
    import pit_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int AW = $clog2(MAX_VERTICES)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pit_cmd_t                cmd,
    input  logic [AW-1:0]           rd_addr,
    input  logic [IDX_W-1:0]        s_vertex_index,
    input  logic signed [LON_W-1:0] s_point_lon,
    input  logic signed [LAT_W-1:0] s_point_lat,
    output logic                    pipe_busy,
    output logic                    m_inside_res,
    output logic                    m_too_few_vertices
);

    localparam int VW = LON_W + LAT_W;
    localparam int PW = 2 * LON_W + 1;

    logic [VW-1:0]           rdata;
    logic signed [LON_W-1:0] cur_lon;
    logic signed [LAT_W-1:0] cur_lat;

    logic signed [LON_W-1:0] pt_lon_reg;
    logic signed [LAT_W-1:0] pt_lat_reg;
    logic signed [LON_W-1:0] prev_lon_reg;
    logic signed [LAT_W-1:0] prev_lat_reg;

    // stage 1: vertex read out of table
    logic v1_reg;
    logic first1_reg;
    // stage 2: differences
    logic                  v2_reg;
    logic                  strad2_reg;
    logic signed [LON_W:0] dxp_reg;
    logic signed [LAT_W:0] dy_reg;
    logic signed [LON_W:0] dxe_reg;
    logic signed [LAT_W:0] dyp_reg;
    // stage 3: products
    logic                  v3_reg;
    logic                  strad3_reg;
    logic                  dpos3_reg;
    logic signed [PW-1:0]  lhs_reg;
    logic signed [PW-1:0]  rhs_reg;

    logic signed [LON_W:0] dxp_next;
    logic signed [LAT_W:0] dy_next;
    logic signed [LON_W:0] dxe_next;
    logic signed [LAT_W:0] dyp_next;
    logic                  strad_next;
    logic signed [PW-1:0]  lhs_next;
    logic signed [PW-1:0]  rhs_next;
    logic                  crosses;

    logic inside_reg;
    logic inside_res_reg;
    logic too_few_res_reg;

    pit_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (AW'(s_vertex_index)),
        .wdata ({s_point_lon, s_point_lat}),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign cur_lon = rdata[VW-1:LAT_W];
    assign cur_lat = rdata[LAT_W-1:0];

    // edge from prev (j) to cur (i)
    always_comb begin
        dxp_next   = {pt_lon_reg[LON_W-1], pt_lon_reg} - {cur_lon[LON_W-1], cur_lon};
        dy_next    = {prev_lat_reg[LAT_W-1], prev_lat_reg} - {cur_lat[LAT_W-1], cur_lat};
        dxe_next   = {prev_lon_reg[LON_W-1], prev_lon_reg} - {cur_lon[LON_W-1], cur_lon};
        dyp_next   = {pt_lat_reg[LAT_W-1], pt_lat_reg} - {cur_lat[LAT_W-1], cur_lat};
        strad_next = (cur_lat > pt_lat_reg) != (prev_lat_reg > pt_lat_reg);
    end

    assign lhs_next = dxp_reg * dy_reg;
    assign rhs_next = dxe_reg * dyp_reg;

    // straddling edge has nonzero span, so the sign bit alone gives direction
    assign crosses = dpos3_reg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg     <= 1'b0;
            first1_reg <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            inside_reg <= 1'b0;
        end else begin
            v1_reg     <= cmd.rd_en;
            first1_reg <= cmd.first;
            v2_reg     <= v1_reg && !first1_reg;
            v3_reg     <= v2_reg;
            if (cmd.ld_point) begin
                inside_reg <= 1'b0;
            end else if (v3_reg && strad3_reg && crosses) begin
                inside_reg <= !inside_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_point) begin
            pt_lon_reg <= s_point_lon;
            pt_lat_reg <= s_point_lat;
        end
        if (v1_reg) begin
            prev_lon_reg <= cur_lon;
            prev_lat_reg <= cur_lat;
        end
        dxp_reg    <= dxp_next;
        dy_reg     <= dy_next;
        dxe_reg    <= dxe_next;
        dyp_reg    <= dyp_next;
        strad2_reg <= strad_next;
        lhs_reg    <= lhs_next;
        rhs_reg    <= rhs_next;
        strad3_reg <= strad2_reg;
        dpos3_reg  <= !dy_reg[LAT_W];
        if (cmd.ld_result) begin
            inside_res_reg  <= inside_reg && !cmd.too_few;
            too_few_res_reg <= cmd.too_few;
        end
    end

    assign pipe_busy          = v1_reg || v2_reg || v3_reg;
    assign m_inside_res       = inside_res_reg;
    assign m_too_few_vertices = too_few_res_reg;

endmodule

FILE: rtl/core/pit_checker.sv
module pit_checker
    import pit_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_kind,
    input logic m_valid,
    input logic m_ready,
    input logic m_inside_res,
    input logic m_too_few_vertices
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_inside_res)
                                && $stable(m_too_few_vertices))
        else $error("result changed while stalled");

    a_too_few_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_too_few_vertices |-> !m_inside_res)
        else $error("inside reported with too few vertices");

    // one query at a time
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == KIND_QUERY |=> !s_ready)
        else $error("item taken right after a query");

    // a vertex item never makes a result
    a_vertex_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == KIND_VERTEX && !m_valid |=> !m_valid)
        else $error("result after vertex item");

endmodule

bind point_in_polygon_test pit_checker u_pit_checker (.*);
